// ===== src/cia_pkg.sv =====
package cia_pkg;

    localparam int ENTRIES   = 16;
    localparam int SLOT_BITS = 4;
    localparam int KEY_BITS  = 16;
    localparam int CNT_BITS  = 5;
    localparam int MEAN_BITS = 40;
    localparam int TIME_BITS = 32;
    localparam int SAMP_BITS = 16;
    localparam int SUM_BITS  = 57;
    localparam int DIV_STEPS = SUM_BITS;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_LOOP  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_NOOPEN = 2'd2;

    localparam logic [1:0] CSR_WINDOW = 2'd0;

    typedef struct packed {
        logic load;      // capture input item, run lookup
        logic do_start;  // apply start to looked-up key
        logic end_init;  // begin end update: latch interval, start divide
        logic div_step;  // one restoring-divide step
        logic end_write; // write back mean, count
        logic emit_end;  // present end result
        logic emit_start;
        logic emit_last;
    } cia_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       hit;
        logic       empty;
        logic       div_done;
    } cia_stat_t;

endpackage

// ===== src/cia_datapath.sv =====
module cia_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cia_pkg::cia_cmd_t         cmd,
    output cia_pkg::cia_stat_t        stat,
    input  logic [1:0]                in_kind,
    input  logic [15:0]               in_key,
    input  logic [31:0]               in_time,
    input  logic [15:0]               window,
    output logic [93:0]               res_data,
    output logic                      res_last
);
    import cia_pkg::*;

    logic [KEY_BITS-1:0]  key_reg      [ENTRIES];
    logic [TIME_BITS-1:0] start_reg    [ENTRIES];
    logic [TIME_BITS-1:0] ivl_reg      [ENTRIES];
    logic [MEAN_BITS-1:0] mean_reg     [ENTRIES];
    logic [SAMP_BITS-1:0] samp_reg     [ENTRIES];
    logic [CNT_BITS-1:0]  used_reg;

    logic [1:0]           kind_reg;
    logic [KEY_BITS-1:0]  ikey_reg;
    logic [TIME_BITS-1:0] itime_reg;
    logic                 hit_reg;
    logic [SLOT_BITS-1:0] slot_reg;

    logic [SUM_BITS-1:0]  quo_reg;
    logic [SUM_BITS-1:0]  rem_reg;
    logic [SAMP_BITS:0]   den_reg;
    logic [6:0]           step_reg;

    logic                 f_hit;
    logic [SLOT_BITS-1:0] f_slot;
    logic [SLOT_BITS-1:0] s_slot;
    logic [TIME_BITS-1:0] len;
    logic [SUM_BITS-1:0]  sum;
    logic [SUM_BITS-1:0]  rem_sh;
    logic                 full;

    // parallel key match over allocated slots
    always_comb
    begin
        f_hit  = 1'b0;
        f_slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (CNT_BITS'(i) < used_reg && key_reg[i] == in_key[KEY_BITS-1:0])
            begin
                f_hit  = 1'b1;
                f_slot = SLOT_BITS'(i);
            end
        end
    end

    assign full   = (used_reg == CNT_BITS'(ENTRIES));
    assign s_slot = hit_reg ? slot_reg : used_reg[SLOT_BITS-1:0];
    assign len    = itime_reg - start_reg[slot_reg];
    assign sum    = SUM_BITS'(mean_reg[slot_reg]) * SUM_BITS'(samp_reg[slot_reg])
                  + SUM_BITS'({len, 8'd0});
    assign rem_sh = {rem_reg[SUM_BITS-2:0], quo_reg[SUM_BITS-1]};

    assign stat.kind     = kind_reg;
    assign stat.hit      = hit_reg;
    assign stat.empty    = (used_reg == '0);
    assign stat.div_done = (step_reg == 7'(DIV_STEPS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                key_reg[i]   <= '0;
                start_reg[i] <= '0;
                ivl_reg[i]   <= '0;
                mean_reg[i]  <= '0;
                samp_reg[i]  <= '0;
            end
            kind_reg  <= '0;
            ikey_reg  <= '0;
            itime_reg <= '0;
            hit_reg   <= 1'b0;
            slot_reg  <= '0;
            quo_reg   <= '0;
            rem_reg   <= '0;
            den_reg   <= '0;
            step_reg  <= '0;
            res_last  <= 1'b0;
            res_data  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                kind_reg  <= in_kind;
                ikey_reg  <= in_key[KEY_BITS-1:0];
                itime_reg <= in_time;
                hit_reg   <= f_hit;
                slot_reg  <= f_slot;
            end
            if (cmd.do_start)
            begin
                if (hit_reg || !full)
                begin
                    start_reg[s_slot] <= itime_reg;
                    if (!hit_reg)
                    begin
                        key_reg[s_slot] <= ikey_reg;
                        used_reg        <= used_reg + 1'b1;
                    end
                    res_data <= {samp_reg[s_slot], mean_reg[s_slot],
                                 ivl_reg[s_slot], s_slot, ST_OK};
                end
                else
                    res_data <= {92'd0, ST_FULL};
                res_last <= 1'b1;
            end
            if (cmd.end_init)
            begin
                ivl_reg[slot_reg] <= len;
                quo_reg  <= sum;
                rem_reg  <= '0;
                den_reg  <= {1'b0, samp_reg[slot_reg]} + 1'b1;
                step_reg <= '0;
            end
            if (cmd.div_step)
            begin
                if (rem_sh >= SUM_BITS'(den_reg))
                begin
                    rem_reg <= rem_sh - SUM_BITS'(den_reg);
                    quo_reg <= {quo_reg[SUM_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[SUM_BITS-2:0], 1'b0};
                end
                step_reg <= step_reg + 1'b1;
            end
            if (cmd.end_write)
            begin
                mean_reg[slot_reg] <= quo_reg[MEAN_BITS-1:0];
                if (samp_reg[slot_reg] < window)
                    samp_reg[slot_reg] <= samp_reg[slot_reg] + 1'b1;
            end
            if (cmd.emit_end)
            begin
                if (hit_reg)
                    res_data <= {samp_reg[slot_reg], mean_reg[slot_reg],
                                 ivl_reg[slot_reg], slot_reg, ST_OK};
                else
                    res_data <= {92'd0, ST_NOOPEN};
                res_last <= cmd.emit_last;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_BITS'(ENTRIES))
        else $error("slot count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> step_reg < 7'(DIV_STEPS))
        else $error("divide overrun");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.end_write |-> hit_reg)
        else $error("write back without hit");
endmodule

// ===== src/cia_ctrl.sv =====
module cia_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  cia_pkg::cia_stat_t stat,
    output cia_pkg::cia_cmd_t  cmd
);
    import cia_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DISP  = 6'b000010,
        S_DIV   = 6'b000100,
        S_WB    = 6'b001000,
        S_OUT   = 6'b010000,
        S_START = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   more_reg, more_next;
    logic   ov_reg, ov_next;
    logic   start_after;

    // result register is only rewritten once it has drained, so input may load meanwhile
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign start_after = (stat.kind == KIND_LOOP);

    always_comb
    begin
        state_next = state_reg;
        more_next  = more_reg;
        ov_next    = ov_reg && !out_ready;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                priority if (stat.kind == KIND_START ||
                             (stat.kind == KIND_LOOP && stat.empty))
                    state_next = S_START;
                else if (stat.kind == KIND_END || stat.kind == KIND_LOOP)
                begin
                    more_next = start_after;
                    if (stat.hit)
                    begin
                        cmd.end_init = 1'b1;
                        state_next   = S_DIV;
                    end
                    else
                        state_next = S_WB;
                end
                else
                    state_next = S_IDLE;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    cmd.div_step = 1'b0;
                    state_next   = S_WB;
                end
            end
            S_WB:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.end_write = stat.hit;
                    state_next    = S_OUT;
                end
            end
            S_OUT:
            begin
                cmd.emit_end  = 1'b1;
                cmd.emit_last = !more_reg;
                ov_next       = 1'b1;
                state_next    = more_reg ? S_START : S_IDLE;
            end
            S_START:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.do_start   = 1'b1;
                    cmd.emit_start = 1'b1;
                    ov_next        = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            more_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            more_reg  <= more_next;
            ov_reg    <= ov_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_end || cmd.do_start) |-> (!ov_reg || out_ready))
        else $error("result overwritten");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_DISP)
        else $error("load without dispatch");
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
endmodule

// ===== src/checkpoint_interval_averager_top.sv =====
// Sequence: a start passes S_DISP, S_START; an end passes S_DISP, S_DIV (57-step
// restoring divide), S_WB, S_OUT; an unopened key skips S_DIV; a loop adds S_START.
// Throughput: one item at a time; the serial divider of the 57-bit weighted
// sum sets the time per end item, a new item is taken once the last result is registered.
// Reset: rst_n asynchronous active low; table, slot count clear, window returns to 100.
module checkpoint_interval_averager_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [55:0]  s_tdata,   // kind[1:0], point_key[17:2], time_us[49:18]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // status[1:0], slot[5:2], interval[37:6],
                                    // mean_interval[77:38], samples[93:78]
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import cia_pkg::*;

    cia_cmd_t     cmd;
    cia_stat_t    stat;
    logic [15:0]  window_reg;
    logic [93:0]  res;

    assign pready = 1'b1;
    assign prdata = (paddr == CSR_WINDOW) ? {16'd0, window_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= 16'd100;
        else if (psel && penable && pwrite && paddr[1:0] == {CSR_WINDOW})
            window_reg <= pwdata[15:0];
    end

    cia_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cia_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_kind  (s_tdata[1:0]),
        .in_key   (s_tdata[17:2]),
        .in_time  (s_tdata[49:18]),
        .window   (window_reg),
        .res_data (res),
        .res_last (m_tlast)
    );

    // res packs status, slot, interval, mean, samples from the lowest bit up
    assign m_tdata = {2'd0, res};
endmodule
